// File: rtl/mbrf_pkg.sv
// mbrf_pkg: shared types, constants and the crc-16 byte step for the request framer
// no dependencies; used by mbrf_slot_state, modbus_rtu_request_framer and the bench
package mbrf_pkg;

  localparam int unsigned Slots   = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned InDataW = 72;
  localparam int unsigned FrameLen = 8;
  localparam int unsigned CntW    = 3;

  localparam logic [7:0]  FcReadFirst = 8'd1;
  localparam logic [7:0]  FcReadLast  = 8'd4;
  localparam logic [7:0]  FcWriteCoil = 8'd5;
  localparam logic [7:0]  FcWriteReg  = 8'd6;

  localparam logic [15:0] CoilOn   = 16'hFF00;
  localparam logic [15:0] CoilOff  = 16'h0000;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  localparam logic [CntW-1:0] IdxNode   = 3'd0;
  localparam logic [CntW-1:0] IdxFunc   = 3'd1;
  localparam logic [CntW-1:0] IdxRegHi  = 3'd2;
  localparam logic [CntW-1:0] IdxRegLo  = 3'd3;
  localparam logic [CntW-1:0] IdxWordHi = 3'd4;
  localparam logic [CntW-1:0] IdxWordLo = 3'd5;
  localparam logic [CntW-1:0] IdxCrcLo  = 3'd6;
  localparam logic [CntW-1:0] IdxCrcHi  = 3'd7;

  typedef enum logic [1:0] {
    StByte        = 2'd0,
    StSuppressed  = 2'd1,
    StUnsupported = 2'd2
  } status_e;

  typedef struct packed {
    logic        send;
    status_e     status;
    logic [15:0] word2;
  } decision_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/mbrf_slot_state.sv
// mbrf_slot_state: per-slot last value and sent-once flags, and the send decision
// depends on mbrf_pkg
module mbrf_slot_state (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [mbrf_pkg::SlotW-1:0] slot_i,
  input  logic [7:0]                func_code_i,
  input  logic [15:0]               write_value_i,
  input  logic [15:0]               quantity_i,
  input  logic                      continuous_i,
  output mbrf_pkg::decision_t       decision_o
);

  logic [15:0] last_value_q [mbrf_pkg::Slots];
  logic [mbrf_pkg::Slots-1:0] sent_once_q;
  logic [15:0] cur_value;
  logic        cur_sent;
  logic        changed;

  assign cur_value = last_value_q[slot_i];
  assign cur_sent  = sent_once_q[slot_i];
  assign changed   = write_value_i != cur_value;

  always_comb begin
    decision_o.send   = 1'b0;
    decision_o.status = mbrf_pkg::StUnsupported;
    decision_o.word2  = quantity_i;
    if (func_code_i >= mbrf_pkg::FcReadFirst && func_code_i <= mbrf_pkg::FcReadLast) begin
      decision_o.send   = 1'b1;
      decision_o.status = mbrf_pkg::StByte;
    end else if (func_code_i == mbrf_pkg::FcWriteCoil) begin
      decision_o.send   = continuous_i || changed || !cur_sent;
      decision_o.status = decision_o.send ? mbrf_pkg::StByte : mbrf_pkg::StSuppressed;
      decision_o.word2  = (write_value_i != 16'h0000) ? mbrf_pkg::CoilOn : mbrf_pkg::CoilOff;
    end else if (func_code_i == mbrf_pkg::FcWriteReg) begin
      decision_o.send   = continuous_i || changed;
      decision_o.status = decision_o.send ? mbrf_pkg::StByte : mbrf_pkg::StSuppressed;
      decision_o.word2  = write_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mbrf_pkg::Slots; i++) begin
        last_value_q[i] <= 16'h0000;
      end
      sent_once_q <= '0;
    end else if (load_i && decision_o.send) begin
      if (func_code_i == mbrf_pkg::FcWriteCoil) begin
        last_value_q[slot_i] <= write_value_i;
        sent_once_q[slot_i]  <= 1'b1;
      end else if (func_code_i == mbrf_pkg::FcWriteReg) begin
        last_value_q[slot_i] <= write_value_i;
      end
    end
  end

  a_coil_marks_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && decision_o.send && func_code_i == mbrf_pkg::FcWriteCoil
    |=> sent_once_q[$past(slot_i)])
    else $error("coil send did not set sent-once flag");

  a_suppress_keeps_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && !decision_o.send
    |=> last_value_q[$past(slot_i)] == $past(cur_value))
    else $error("suppressed or unsupported command changed the slot value");

  a_unsupported_never_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decision_o.status == mbrf_pkg::StUnsupported |-> !decision_o.send)
    else $error("unsupported function marked for sending");

endmodule

// File: rtl/modbus_rtu_request_framer.sv
// modbus_rtu_request_framer: top level, command register, slot state and byte serialiser
// depends on mbrf_pkg and mbrf_slot_state
//
// channel  | direction | tdata                                        | tuser       | tlast
// s_axis   | in        | slot, node, func_code, start_register,       | continuous  | -
//          |           | quantity, write_value (68 bits, 72 wide)     |             |
// m_axis   | out       | frame_byte                                   | status      | last
//
// a sent command gives eight bytes, one per cycle while m_axis is ready; a suppressed or unsupported one gives one item
// the crc is folded one byte per cycle as bytes 0 to 5 leave, so the byte serialiser sets the rate
// the command register takes the next item while the serialiser still emits, so frames run
// back to back; reset clears the slot table, the sent-once flags and both valid flags;
// output stalls hold the byte and its position
module modbus_rtu_request_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // slot[3:0] node[11:4] func_code[19:12] start_register[35:20] quantity[51:36]
  // write_value[67:52], zero above
  input  logic [mbrf_pkg::InDataW-1:0]  s_axis_tdata_i,
  // continuous[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // frame_byte[7:0]
  output logic [7:0]                    m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  logic                       cmd_valid_q;
  logic [mbrf_pkg::SlotW-1:0] cmd_slot_q;
  logic [7:0]                 cmd_node_q;
  logic [7:0]                 cmd_fc_q;
  logic [15:0]                cmd_reg_q;
  logic [15:0]                cmd_qty_q;
  logic [15:0]                cmd_val_q;
  logic                       cmd_cont_q;

  logic                       busy_q;
  logic                       single_q;
  mbrf_pkg::status_e          status_q;
  logic [mbrf_pkg::CntW-1:0]  cnt_q;
  logic [7:0]                 node_q;
  logic [7:0]                 fc_q;
  logic [15:0]                reg_q;
  logic [15:0]                word2_q;
  logic [15:0]                crc_q;

  mbrf_pkg::decision_t        decision;
  logic [7:0]                 cur_byte;
  logic                       out_last;
  logic                       fire_out;
  logic                       done;
  logic                       load;
  logic                       fire_in;

  assign fire_out = busy_q && m_axis_tready_i;
  assign out_last = single_q || (cnt_q == mbrf_pkg::IdxCrcHi);
  assign done     = fire_out && out_last;
  assign load     = cmd_valid_q && (!busy_q || done);
  assign s_axis_tready_o = !cmd_valid_q || load;
  assign fire_in  = s_axis_tvalid_i && s_axis_tready_o;

  mbrf_slot_state u_slot_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .slot_i        (cmd_slot_q),
    .func_code_i   (cmd_fc_q),
    .write_value_i (cmd_val_q),
    .quantity_i    (cmd_qty_q),
    .continuous_i  (cmd_cont_q),
    .decision_o    (decision)
  );

  always_comb begin
    case (cnt_q)
      mbrf_pkg::IdxNode:   cur_byte = node_q;
      mbrf_pkg::IdxFunc:   cur_byte = fc_q;
      mbrf_pkg::IdxRegHi:  cur_byte = reg_q[15:8];
      mbrf_pkg::IdxRegLo:  cur_byte = reg_q[7:0];
      mbrf_pkg::IdxWordHi: cur_byte = word2_q[15:8];
      mbrf_pkg::IdxWordLo: cur_byte = word2_q[7:0];
      mbrf_pkg::IdxCrcLo:  cur_byte = crc_q[7:0];
      mbrf_pkg::IdxCrcHi:  cur_byte = crc_q[15:8];
      default:             cur_byte = 8'h00;
    endcase
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = single_q ? 8'h00 : cur_byte;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tlast_o  = out_last;

  // command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (fire_in) begin
      cmd_valid_q <= 1'b1;
    end else if (load) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      cmd_slot_q <= s_axis_tdata_i[3:0];
      cmd_node_q <= s_axis_tdata_i[11:4];
      cmd_fc_q   <= s_axis_tdata_i[19:12];
      cmd_reg_q  <= s_axis_tdata_i[35:20];
      cmd_qty_q  <= s_axis_tdata_i[51:36];
      cmd_val_q  <= s_axis_tdata_i[67:52];
      cmd_cont_q <= s_axis_tuser_i;
    end
  end

  // byte serialiser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      single_q <= 1'b0;
      status_q <= mbrf_pkg::StByte;
      cnt_q    <= '0;
    end else if (load) begin
      busy_q   <= 1'b1;
      single_q <= !decision.send;
      status_q <= decision.status;
      cnt_q    <= '0;
    end else if (done) begin
      busy_q   <= 1'b0;
    end else if (fire_out) begin
      cnt_q    <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      node_q  <= cmd_node_q;
      fc_q    <= cmd_fc_q;
      reg_q   <= cmd_reg_q;
      word2_q <= decision.word2;
      crc_q   <= mbrf_pkg::CrcInit;
    end else if (fire_out && cnt_q < mbrf_pkg::IdxCrcLo) begin
      crc_q   <= mbrf_pkg::crc16_byte(crc_q, cur_byte);
    end
  end

  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !load |=> !busy_q)
    else $error("serialiser still busy after final item");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_out && !out_last |=> cnt_q == $past(cnt_q) + 1'b1 && busy_q)
    else $error("byte position did not advance");

  a_single_is_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && single_q |-> status_q != mbrf_pkg::StByte && cnt_q == '0)
    else $error("single result carries frame status or position");

  a_frame_is_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !single_q |-> status_q == mbrf_pkg::StByte)
    else $error("frame byte with non-byte status");

endmodule

// File: dv/tb_modbus_rtu_request_framer.sv
// tb_modbus_rtu_request_framer: self-checking bench for the modbus rtu request framer
// predicts each request frame (node, function, words, crc-16) and the per-slot suppression state
// depends on mbrf_pkg and modbus_rtu_request_framer
`timescale 1ns / 100ps

module tb_modbus_rtu_request_framer;

  localparam logic [7:0] FcCoil = mbrf_pkg::FcWriteCoil;
  localparam logic [7:0] FcReg  = mbrf_pkg::FcWriteReg;

  typedef struct packed {
    logic [3:0]  slot;
    logic [7:0]  node;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] value;
    logic        cont;
  } command_t;

  typedef struct packed {
    logic [7:0]          data;
    logic                tail;
    mbrf_pkg::status_e   status;
  } frame_item_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          s_valid = 1'b0;
  logic                          s_ready;
  logic [mbrf_pkg::InDataW-1:0]  s_tdata;
  logic                          s_tuser;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [7:0]                    m_tdata;
  logic [1:0]                    m_tuser;
  logic                          m_tlast;

  command_t             offer = '0;
  command_t             pending_cmds[$];
  frame_item_t          expected_bytes[$];
  logic [15:0]          coil_reg_value[mbrf_pkg::Slots];
  logic                 coil_written[mbrf_pkg::Slots];
  logic                 in_taken = 1'b0;
  logic                 out_taken = 1'b0;
  int unsigned          cmds_taken = 0;
  int unsigned          total_cmds = 0;
  int unsigned          mismatches = 0;
  int                   tx_gap = 0;
  int                   tx_calm = 0;
  int                   rx_gap = 0;
  int                   rx_calm = 0;
  int                   rx_hold = 0;
  logic                 rx_hold_done = 1'b0;

  // slot[3:0] node[11:4] func_code[19:12] start_register[35:20] quantity[51:36]
  // write_value[67:52], zero above
  assign s_tdata = {4'b0, offer.value, offer.qty, offer.addr, offer.fc, offer.node, offer.slot};
  assign s_tuser = offer.cont;

  modbus_rtu_request_framer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 11);
  endfunction

  function automatic command_t mk_cmd(logic [3:0] slot, logic [7:0] node, logic [7:0] fc,
                                      logic [15:0] addr, logic [15:0] qty,
                                      logic [15:0] value, logic cont);
    command_t c;
    c.slot  = slot;
    c.node  = node;
    c.fc    = fc;
    c.addr  = addr;
    c.qty   = qty;
    c.value = value;
    c.cont  = cont;
    return c;
  endfunction

  function automatic command_t random_cmd();
    command_t c;
    int unsigned pick;
    c.slot  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    c.node  = 8'($urandom);
    c.addr  = 16'($urandom);
    c.qty   = 16'($urandom);
    c.cont  = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 19);
    if (pick < 6) c.fc = 8'($urandom_range(1, 4));
    else if (pick < 11) c.fc = FcCoil;
    else if (pick < 16) c.fc = FcReg;
    else if (pick < 18) c.fc = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd7;
    else c.fc = 8'($urandom_range(7, 255));
    // narrow value set so that repeats, and hence suppression, are common
    case ($urandom_range(0, 7))
      0: c.value = 16'h0000;
      1: c.value = 16'h0001;
      2: c.value = 16'hFFFF;
      3: c.value = 16'h00FF;
      default: c.value = 16'($urandom);
    endcase
    return c;
  endfunction

  task automatic predict_frame(input command_t c);
    logic [15:0]        word2;
    logic [7:0]         frame [mbrf_pkg::FrameLen];
    logic [15:0]        crc;
    logic               fire;
    mbrf_pkg::status_e  why;
    frame_item_t        item;
    fire = 1'b1;
    why = mbrf_pkg::StByte;
    word2 = '0;
    if (c.fc >= mbrf_pkg::FcReadFirst && c.fc <= mbrf_pkg::FcReadLast) begin
      word2 = c.qty;
    end else if (c.fc == FcCoil) begin
      if (c.cont || c.value != coil_reg_value[c.slot] || !coil_written[c.slot]) begin
        word2 = (c.value != 16'h0000) ? mbrf_pkg::CoilOn : mbrf_pkg::CoilOff;
        coil_written[c.slot] = 1'b1;
        coil_reg_value[c.slot] = c.value;
      end else begin
        fire = 1'b0;
        why = mbrf_pkg::StSuppressed;
      end
    end else if (c.fc == FcReg) begin
      if (c.cont || c.value != coil_reg_value[c.slot]) begin
        word2 = c.value;
        coil_reg_value[c.slot] = c.value;
      end else begin
        fire = 1'b0;
        why = mbrf_pkg::StSuppressed;
      end
    end else begin
      fire = 1'b0;
      why = mbrf_pkg::StUnsupported;
    end
    if (!fire) begin
      item.data = 8'h00;
      item.tail = 1'b1;
      item.status = why;
      expected_bytes.push_back(item);
    end else begin
      frame[0] = c.node;
      frame[1] = c.fc;
      frame[2] = c.addr[15:8];
      frame[3] = c.addr[7:0];
      frame[4] = word2[15:8];
      frame[5] = word2[7:0];
      crc = mbrf_pkg::CrcInit;
      for (int k = 0; k < 6; k++) begin
        crc = crc ^ {8'h00, frame[k]};
        for (int b = 0; b < 8; b++) begin
          crc = crc[0] ? ((crc >> 1) ^ mbrf_pkg::CrcPoly) : (crc >> 1);
        end
      end
      frame[6] = crc[7:0];
      frame[7] = crc[15:8];
      for (int k = 0; k < mbrf_pkg::FrameLen; k++) begin
        item.data = frame[k];
        item.tail = (k == mbrf_pkg::FrameLen - 1);
        item.status = mbrf_pkg::StByte;
        expected_bytes.push_back(item);
      end
    end
  endtask

  // monitor and scoreboard: outputs are checked before the new command is predicted
  always @(posedge clk_i) begin : monitor
    frame_item_t got;
    frame_item_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got.data = m_tdata;
        got.tail = m_tlast;
        got.status = mbrf_pkg::status_e'(m_tuser);
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual byte %h last %b status %0d",
                   $time, got.data, got.tail, got.status);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data) begin
            $display("%0t: frame byte expected %h actual %h", $time, want.data, got.data);
            mismatches++;
          end
          if (got.tail !== want.tail) begin
            $display("%0t: last expected %b actual %b", $time, want.tail, got.tail);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
          end
        end
      end
      if (s_valid && s_ready) begin
        predict_frame(offer);
        cmds_taken++;
      end
    end
    in_taken  <= rst_ni && s_valid && s_ready;
    out_taken <= rst_ni && m_valid && m_ready;
  end

  always @(negedge clk_i) begin : driver
    if (rst_ni && (!s_valid || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        offer <= pending_cmds.pop_front();
        s_valid <= 1'b1;
        tx_gap = draw_wait(tx_calm);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_taken) rx_gap = draw_wait(rx_calm);
      // one long hold-off so the framer backs up and stalls its input
      if (!rx_hold_done && cmds_taken >= 60) begin
        rx_hold = 300;
        rx_hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < mbrf_pkg::Slots; i++) begin
      coil_reg_value[i] = 16'h0000;
      coil_written[i] = 1'b0;
    end
    // read functions, the first two at the field extremes
    pending_cmds.push_back(mk_cmd(4'd0, 8'h00, 8'd3, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd15, 8'hFF, 8'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    pending_cmds.push_back(mk_cmd(4'd2, 8'h11, 8'd1, 16'h0013, 16'h0025, 16'h0000, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd3, 8'h5A, 8'd2, 16'hA5A5, 16'h5A5A, 16'h1234, 1'b1));
    // coil: first use sends even with an unchanged zero value
    pending_cmds.push_back(mk_cmd(4'd0, 8'h01, FcCoil, 16'h00AC, 16'h0, 16'h0000, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd0, 8'h01, FcCoil, 16'h00AC, 16'h0, 16'h0000, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd0, 8'h01, FcCoil, 16'h00AC, 16'h0, 16'h0000, 1'b1));
    pending_cmds.push_back(mk_cmd(4'd0, 8'h01, FcCoil, 16'h00AC, 16'h0, 16'h1234, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd0, 8'h01, FcCoil, 16'h00AC, 16'h0, 16'h5678, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd0, 8'h01, FcCoil, 16'h00AC, 16'h0, 16'h5678, 1'b0));
    // register write: no first-use rule
    pending_cmds.push_back(mk_cmd(4'd1, 8'h22, FcReg, 16'h0001, 16'h0, 16'h0000, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd1, 8'h22, FcReg, 16'h0001, 16'h0, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd1, 8'h22, FcReg, 16'h0001, 16'h0, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd1, 8'h22, FcReg, 16'h0001, 16'h0, 16'hFFFF, 1'b1));
    pending_cmds.push_back(mk_cmd(4'd15, 8'hFE, FcReg, 16'hFFFF, 16'h0, 16'h0000, 1'b1));
    // coil and register share the stored value of a slot
    pending_cmds.push_back(mk_cmd(4'd1, 8'h33, FcCoil, 16'h0002, 16'h0, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd0, 8'h33, FcReg, 16'h0003, 16'h0, 16'h5678, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd15, 8'h44, FcCoil, 16'h8000, 16'h0, 16'h0001, 1'b0));
    // unsupported function codes
    pending_cmds.push_back(mk_cmd(4'd4, 8'h55, 8'd0, 16'h1111, 16'h2222, 16'h3333, 1'b0));
    pending_cmds.push_back(mk_cmd(4'd5, 8'h66, 8'd7, 16'h4444, 16'h5555, 16'h6666, 1'b1));
    pending_cmds.push_back(mk_cmd(4'd6, 8'h77, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    for (int i = 0; i < 200; i++) pending_cmds.push_back(random_cmd());
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken < total_cmds) @(posedge clk_i);
    while (expected_bytes.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
